>>> rtl/core/pfla_pkg.sv
// Shared types and constants of the page free-list allocator.
package pfla_pkg;

    // Request kinds.
    localparam logic [2:0] K_MALLOC     = 3'd0;
    localparam logic [2:0] K_OPEN       = 3'd1;
    localparam logic [2:0] K_RESERVE    = 3'd2;
    localparam logic [2:0] K_FREE       = 3'd3;
    localparam logic [2:0] K_LOCK_SETUP = 3'd4;
    localparam logic [2:0] K_LOCK_DONE  = 3'd5;

    // Reply status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_CONFLICT = 3'd2;
    localparam logic [2:0] ST_GRANTED  = 3'd3;
    localparam logic [2:0] ST_EXISTS   = 3'd4;

    // Page tag codes; a tag of TAG_LINK or more links to page (tag - TAG_LINK).
    localparam int TAG_UNSEEN     = 0;
    localparam int TAG_END        = 1;
    localparam int TAG_IN_USE     = 2;
    localparam int TAG_LOCK_SETUP = 3;
    localparam int TAG_LOCK       = 4;
    localparam int TAG_RESERVED   = 5;
    localparam int TAG_LINK       = 6;

    // Smallest width of the range address walker.
    localparam int ADDR_MIN_W = 12;

    typedef logic [3:0] t_op;

    // Datapath operations issued by the controller.
    localparam t_op OP_NONE     = 4'd0;
    localparam t_op OP_CLEAR    = 4'd1;
    localparam t_op OP_LOAD     = 4'd2;
    localparam t_op OP_M_HEAD   = 4'd3;
    localparam t_op OP_M_STEP   = 4'd4;
    localparam t_op OP_M_SPLICE = 4'd5;
    localparam t_op OP_M_MARK   = 4'd6;
    localparam t_op OP_P_RD     = 4'd7;
    localparam t_op OP_P_WR     = 4'd8;
    localparam t_op OP_R_RD     = 4'd9;
    localparam t_op OP_R_WR     = 4'd10;
    localparam t_op OP_L_RD     = 4'd11;
    localparam t_op OP_L_WR     = 4'd12;
    localparam t_op OP_LD       = 4'd13;
    localparam t_op OP_REPLY    = 4'd14;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic head_ok;
        logic step_fail;
        logic step_done;
        logic mark_last;
        logic cnt_zero;
        logic res_stop;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/core/pfla_dp.sv
// Datapath of the page allocator: tag memory, list head, walkers and reply register.
module pfla_dp #(
    parameter int NUM_PAGES = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pfla_pkg::t_cmd i_cmd,
    output pfla_pkg::t_stat o_stat,
    input  logic [2:0]    i_kind,
    input  logic [9:0]    i_first_page,
    input  logic [10:0]   i_page_count,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [2:0]    o_reply_kind,
    output logic [2:0]    o_status,
    output logic [9:0]    o_start_page,
    output logic [10:0]   o_granted_pages
);
    import pfla_pkg::*;

    localparam int IW  = $clog2(NUM_PAGES);
    localparam int TW  = $clog2(NUM_PAGES + TAG_LINK);
    localparam int SW  = $clog2(NUM_PAGES + 2);
    localparam int CW  = (SW > 11) ? SW : 11;
    localparam int AW  = (IW > ADDR_MIN_W) ? IW : ADDR_MIN_W;

    logic [TW-1:0] mem [NUM_PAGES];
    logic [TW-1:0] r_rd;
    logic [TW-1:0] r_head;
    logic [IW-1:0] r_clr;
    logic [2:0]    r_kind;
    logic [10:0]   r_cnt;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_want;
    logic [CW-1:0] r_steps;
    logic [CW-1:0] r_acc;
    logic          r_have_prev;
    logic          r_have_start;
    logic [IW-1:0] r_cur;
    logic [IW-1:0] r_prev;
    logic [IW-1:0] r_start;
    logic [TW-1:0] r_prev_tag;
    logic [2:0]    r_status;
    logic [9:0]    r_sp;
    logic [10:0]   r_gp;
    logic          r_o_valid;
    logic [2:0]    r_o_kind;
    logic [2:0]    r_o_status;
    logic [9:0]    r_o_sp;
    logic [10:0]   r_o_gp;

    logic          we;
    logic [IW-1:0] wa;
    logic [TW-1:0] wd;
    logic [IW-1:0] ra;

    logic [TW-1:0] head_off;
    logic [TW-1:0] rd_off;
    logic          head_ok;
    logic          link_ok;
    logic          rd_ok;
    logic          contig;
    logic [CW-1:0] acc_n;
    logic          reach;
    logic          step_fail;
    logic          addr_in;
    logic [TW-1:0] need;
    logic          res_stop;
    logic [IW-1:0] addr_idx;
    logic [CW-1:0] run_first;
    logic          out_free;

    // Link decode of the list head and of the tag just read.
    assign head_off = r_head - TW'(TAG_LINK);
    assign rd_off   = r_rd - TW'(TAG_LINK);
    assign head_ok  = (r_head >= TW'(TAG_LINK)) && (32'(head_off) < NUM_PAGES);
    assign link_ok  = (r_rd >= TW'(TAG_LINK)) && (32'(rd_off) < NUM_PAGES);
    assign rd_ok    = (r_rd == TW'(TAG_END)) || (r_rd >= TW'(TAG_LINK));

    // Run tracking of the malloc walk.
    assign contig    = !r_have_prev || ({1'b0, r_cur} == ({1'b0, r_prev} + 1'b1));
    assign acc_n     = contig ? (r_acc + 1'b1) : CW'(1);
    assign reach     = acc_n >= r_want;
    assign step_fail = !rd_ok || (32'(r_steps) > NUM_PAGES) || (!reach && !link_ok);
    assign run_first = CW'(r_prev) + CW'(1) - r_acc;

    // Range walker checks.
    assign addr_idx = IW'(r_addr);
    assign addr_in  = 32'(r_addr) < NUM_PAGES;
    assign need     = (r_kind == K_OPEN) ? TW'(TAG_UNSEEN) : TW'(TAG_IN_USE);
    assign res_stop = addr_in && (r_rd != TW'(TAG_UNSEEN)) && (r_rd != TW'(TAG_RESERVED))
                      && (r_rd != TW'(TAG_LOCK)) && (r_rd != TW'(TAG_LOCK_SETUP));
    assign out_free = !r_o_valid || i_ready;

    // Status back to the controller.
    always_comb begin
        o_stat.clear_last = (32'(r_clr) == NUM_PAGES - 1);
        o_stat.head_ok    = head_ok;
        o_stat.step_fail  = step_fail;
        o_stat.step_done  = !step_fail && reach;
        o_stat.mark_last  = (addr_idx == r_prev);
        o_stat.cnt_zero   = (r_cnt == 11'd0);
        o_stat.res_stop   = res_stop;
        o_stat.out_free   = out_free;
    end

    // Memory port selection.
    always_comb begin
        we = 1'b0;
        wa = addr_idx;
        wd = TW'(TAG_UNSEEN);
        ra = addr_idx;
        case (i_cmd.op)
            OP_CLEAR: begin
                we = 1'b1;
                wa = r_clr;
            end
            OP_M_HEAD: ra = IW'(head_off);
            OP_M_STEP: ra = IW'(rd_off);
            OP_M_SPLICE: begin
                we = r_have_start;
                wa = r_start;
                wd = r_prev_tag;
            end
            OP_M_MARK: begin
                we = 1'b1;
                wd = TW'(TAG_IN_USE);
            end
            OP_P_WR: begin
                we = addr_in && (r_rd == need);
                wd = r_head;
            end
            OP_R_WR: begin
                we = addr_in && (r_rd == TW'(TAG_UNSEEN));
                wd = TW'(TAG_RESERVED);
            end
            OP_L_WR: begin
                we = addr_in && (r_rd == TW'(TAG_RESERVED));
                wd = TW'(TAG_LOCK_SETUP);
            end
            OP_LD: begin
                we = addr_in;
                wd = TW'(TAG_LOCK);
            end
            default: ;
        endcase
    end

    // Tag memory with registered read.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[ra];
    end

    // Control registers: clear counter, list head and reply valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_head    <= TW'(TAG_END);
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.op == OP_M_SPLICE && !r_have_start) begin
                r_head <= r_prev_tag;
            end
            if (i_cmd.op == OP_P_WR && addr_in && r_rd == need) begin
                r_head <= TW'(r_addr) + TW'(TAG_LINK);
            end
            if (i_cmd.op == OP_REPLY) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_kind       <= i_kind;
                r_cnt        <= i_page_count;
                r_addr       <= (i_kind == K_RESERVE || i_kind == K_LOCK_SETUP
                                 || i_kind == K_LOCK_DONE)
                                ? AW'(i_first_page)
                                : AW'(i_first_page) + AW'(i_page_count) - AW'(1);
                r_want       <= (i_page_count == 11'd0) ? CW'(1) : CW'(i_page_count);
                r_steps      <= '0;
                r_acc        <= '0;
                r_have_prev  <= 1'b0;
                r_have_start <= 1'b0;
                r_status     <= ST_OK;
                r_sp         <= i_first_page;
                r_gp         <= i_page_count;
            end
            OP_M_HEAD: begin
                r_cur <= IW'(head_off);
                if (!head_ok) begin
                    r_status <= ST_NO_SPACE;
                    r_sp     <= '0;
                    r_gp     <= '0;
                end
            end
            OP_M_STEP: begin
                if (step_fail) begin
                    r_status <= ST_NO_SPACE;
                    r_sp     <= '0;
                    r_gp     <= '0;
                end else begin
                    r_steps     <= r_steps + 1'b1;
                    r_acc       <= acc_n;
                    if (!contig) begin
                        r_start      <= r_prev;
                        r_have_start <= 1'b1;
                    end
                    r_prev      <= r_cur;
                    r_have_prev <= 1'b1;
                    r_prev_tag  <= r_rd;
                    r_cur       <= IW'(rd_off);
                end
            end
            OP_M_SPLICE: begin
                r_addr <= AW'(IW'(run_first));
                r_sp   <= 10'(IW'(run_first));
                r_gp   <= 11'(r_acc);
            end
            OP_M_MARK: r_addr <= r_addr + 1'b1;
            OP_P_WR: begin
                r_cnt  <= r_cnt - 1'b1;
                r_addr <= r_addr - 1'b1;
            end
            OP_R_WR: begin
                if (res_stop) begin
                    r_status <= ST_CONFLICT;
                end
                r_cnt  <= r_cnt - 1'b1;
                r_addr <= r_addr + 1'b1;
            end
            OP_L_WR: begin
                if (!addr_in) begin
                    r_status <= ST_CONFLICT;
                end else if (r_rd == TW'(TAG_RESERVED)) begin
                    r_status <= ST_GRANTED;
                end else if (r_rd == TW'(TAG_LOCK_SETUP) || r_rd == TW'(TAG_LOCK)) begin
                    r_status <= ST_EXISTS;
                end else begin
                    r_status <= ST_CONFLICT;
                end
            end
            default: ;
        endcase
    end

    // Reply output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_REPLY) begin
            r_o_kind   <= r_kind;
            r_o_status <= r_status;
            r_o_sp     <= r_sp;
            r_o_gp     <= r_gp;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_reply_kind    = r_o_kind;
    assign o_status        = r_o_status;
    assign o_start_page    = r_o_sp;
    assign o_granted_pages = r_o_gp;

endmodule

>>> rtl/core/pfla_ctrl.sv
// Controller state machine of the page allocator.
module pfla_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2:0]      i_kind,
    input  pfla_pkg::t_stat i_stat,
    output pfla_pkg::t_cmd  o_cmd
);
    import pfla_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_M_HEAD   = 4'd2;
    localparam logic [3:0] S_M_STEP   = 4'd3;
    localparam logic [3:0] S_M_SPLICE = 4'd4;
    localparam logic [3:0] S_M_MARK   = 4'd5;
    localparam logic [3:0] S_P_RD     = 4'd6;
    localparam logic [3:0] S_P_WR     = 4'd7;
    localparam logic [3:0] S_R_RD     = 4'd8;
    localparam logic [3:0] S_R_WR     = 4'd9;
    localparam logic [3:0] S_L_RD     = 4'd10;
    localparam logic [3:0] S_L_WR     = 4'd11;
    localparam logic [3:0] S_LD       = 4'd12;
    localparam logic [3:0] S_REPLY    = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    // Next state and datapath operation.
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    case (i_kind) inside
                        K_MALLOC:          n_state = S_M_HEAD;
                        K_OPEN, K_FREE:    n_state = S_P_RD;
                        K_RESERVE:         n_state = S_R_RD;
                        K_LOCK_SETUP:      n_state = S_L_RD;
                        K_LOCK_DONE:       n_state = S_LD;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_M_HEAD: begin
                o_cmd.op = OP_M_HEAD;
                n_state  = i_stat.head_ok ? S_M_STEP : S_REPLY;
            end
            S_M_STEP: begin
                o_cmd.op = OP_M_STEP;
                if (i_stat.step_fail) begin
                    n_state = S_REPLY;
                end else if (i_stat.step_done) begin
                    n_state = S_M_SPLICE;
                end
            end
            S_M_SPLICE: begin
                o_cmd.op = OP_M_SPLICE;
                n_state  = S_M_MARK;
            end
            S_M_MARK: begin
                o_cmd.op = OP_M_MARK;
                if (i_stat.mark_last) begin
                    n_state = S_REPLY;
                end
            end
            S_P_RD: begin
                o_cmd.op = OP_P_RD;
                n_state  = i_stat.cnt_zero ? S_REPLY : S_P_WR;
            end
            S_P_WR: begin
                o_cmd.op = OP_P_WR;
                n_state  = S_P_RD;
            end
            S_R_RD: begin
                o_cmd.op = OP_R_RD;
                n_state  = i_stat.cnt_zero ? S_REPLY : S_R_WR;
            end
            S_R_WR: begin
                o_cmd.op = OP_R_WR;
                n_state  = i_stat.res_stop ? S_REPLY : S_R_RD;
            end
            S_L_RD: begin
                o_cmd.op = OP_L_RD;
                n_state  = S_L_WR;
            end
            S_L_WR: begin
                o_cmd.op = OP_L_WR;
                n_state  = S_REPLY;
            end
            S_LD: begin
                o_cmd.op = OP_LD;
                n_state  = S_IDLE;
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_REPLY;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/page_free_list_allocator_unit.sv
// Malloc walks the free list, splices the run out and marks its pages in use; open, free
// and reserve loop over the page range; lock setup reads one page and writes it if it is
// reserved; lock done writes one page and sends no reply. Only one request is taken at a
// time; the list walk and range loops all go through the tag memory.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the tag memory while
// the input ready stays low.
module page_free_list_allocator_unit #(
    parameter int NUM_PAGES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [9:0]  i_first_page,
    input  logic [10:0] i_page_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_reply_kind,
    output logic [2:0]  o_status,
    output logic [9:0]  o_start_page,
    output logic [10:0] o_granted_pages
);
    import pfla_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer.
    pfla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_kind  (i_kind),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Tag memory and working registers.
    pfla_dp #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_kind          (i_kind),
        .i_first_page    (i_first_page),
        .i_page_count    (i_page_count),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_reply_kind    (o_reply_kind),
        .o_status        (o_status),
        .o_start_page    (o_start_page),
        .o_granted_pages (o_granted_pages)
    );

    // The clearing pass never overlaps an accepted beat.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_CLEAR) |-> !o_ready)
        else $error("input accepted during clearing pass");

    // A reply is loaded only into a free output register.
    a_reply_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_REPLY) |-> w_stat.out_free)
        else $error("reply overwrote a pending beat");

    // A loaded reply shows up as a valid beat.
    a_reply_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_REPLY) |=> o_valid)
        else $error("reply beat lost");

    // Reset leaves both channels quiet.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_ready))
        else $error("channel active after reset");

endmodule

>>> tb/tb.sv
// Self-checking testbench of the page free-list allocator unit.
`timescale 1ns / 1ps

module tb;
    import pfla_pkg::*;

    localparam int NUM_PAGES = 1024;
    localparam int DRAIN_CYCLES = 2 * NUM_PAGES + 16;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  status;
        logic [9:0]  start_page;
        logic [10:0] pages;
    } t_reply;

    typedef struct packed {
        logic [9:0]  first;
        logic [10:0] count;
    } t_run;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_kind = '0;
    logic [9:0]  i_first_page = '0;
    logic [10:0] i_page_count = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_reply_kind;
    logic [2:0]  o_status;
    logic [9:0]  o_start_page;
    logic [10:0] o_granted_pages;

    // Mirror of the tag table and list head.
    int     tag_mirror [NUM_PAGES];
    int     head_mirror;
    t_reply replies_due [$];
    t_run   runs_held [$];
    int     failures = 0;
    bit     running = 1'b0;
    bit     idle_on = 1'b1;
    int     holds_asked = 0;
    int     holds_done = 0;
    int     hold_left = 0;
    int     gap_left = 0;

    page_free_list_allocator_unit #(.NUM_PAGES(NUM_PAGES)) dut (.*);

    always #5 i_clk = ~i_clk;

    // Decode a link; true when it names an in-range page that is itself free.
    function automatic bit link_target(input int tag, output int pg);
        int t;
        pg = 0;
        if (tag < TAG_LINK || tag - TAG_LINK >= NUM_PAGES) return 1'b0;
        t = tag_mirror[tag - TAG_LINK];
        if (t != TAG_END && t < TAG_LINK) return 1'b0;
        pg = tag - TAG_LINK;
        return 1'b1;
    endfunction

    // Push pages of a range that carry the given tag, highest page first.
    function automatic void push_pages(input int first, input int count, input int need);
        int a;
        for (int i = count; i > 0; i--) begin
            a = first + i - 1;
            if (a < NUM_PAGES && tag_mirror[a] == need) begin
                tag_mirror[a] = head_mirror;
                head_mirror = a + TAG_LINK;
            end
        end
    endfunction

    // Walk the free list for the first run that is contiguous in list and address.
    function automatic t_reply alloc_run(input int count);
        t_reply r;
        int want, prev, start, cur, nxt, acc, steps, succ, first;
        bit have_prev, have_start, cur_ok, found;
        want = (count == 0) ? 1 : count;
        prev = 0; start = 0; acc = 0; steps = 0;
        have_prev = 0; have_start = 0; found = 0;
        cur_ok = link_target(head_mirror, cur);
        r = '{K_MALLOC, ST_NO_SPACE, 10'd0, 11'd0};
        while (!found) begin
            if (!cur_ok || steps > NUM_PAGES) return r;
            steps++;
            if (!have_prev || cur == prev + 1) begin
                acc++;
            end else begin
                acc = 1;
                start = prev;
                have_start = 1;
            end
            prev = cur;
            have_prev = 1;
            cur_ok = link_target(tag_mirror[cur], nxt);
            cur = nxt;
            found = (acc >= want);
        end
        succ = tag_mirror[prev];
        first = prev + 1 - acc;
        if (have_start) tag_mirror[start] = succ;
        else head_mirror = succ;
        for (int i = first; i <= prev; i++) tag_mirror[i] = TAG_IN_USE;
        r = '{K_MALLOC, ST_OK, first[9:0], acc[10:0]};
        runs_held.push_back('{first[9:0], acc[10:0]});
        return r;
    endfunction

    // Mark unseen pages reserved; a free or in-use page stops the range.
    function automatic logic [2:0] reserve_pages(input int first, input int count);
        int a, t;
        for (int i = 0; i < count; i++) begin
            a = first + i;
            if (a < NUM_PAGES) begin
                t = tag_mirror[a];
                if (t == TAG_UNSEEN) tag_mirror[a] = TAG_RESERVED;
                else if (t != TAG_RESERVED && t != TAG_LOCK && t != TAG_LOCK_SETUP)
                    return ST_CONFLICT;
            end
        end
        return ST_OK;
    endfunction

    // Apply one accepted request to the mirror and queue its reply, if any.
    function automatic void predict_reply(input logic [2:0] kind, input logic [9:0] first,
                                          input logic [10:0] count);
        t_reply r;
        int t;
        r = '{kind, ST_OK, first, count};
        case (kind)
            K_MALLOC: r = alloc_run(int'(count));
            K_OPEN: push_pages(int'(first), int'(count), TAG_UNSEEN);
            K_RESERVE: r.status = reserve_pages(int'(first), int'(count));
            K_FREE: push_pages(int'(first), int'(count), TAG_IN_USE);
            K_LOCK_SETUP: begin
                t = tag_mirror[first];
                r.status = ST_CONFLICT;
                if (t == TAG_RESERVED) begin
                    tag_mirror[first] = TAG_LOCK_SETUP;
                    r.status = ST_GRANTED;
                end else if (t == TAG_LOCK_SETUP || t == TAG_LOCK) begin
                    r.status = ST_EXISTS;
                end
            end
            K_LOCK_DONE: begin
                tag_mirror[first] = TAG_LOCK;
                return;
            end
            default: return;
        endcase
        replies_due.push_back(r);
    endfunction

    // Send one request beat; returns at the edge where it was accepted.
    task automatic send_req(input logic [2:0] kind, input int first, input int count);
        i_valid <= 1'b1;
        i_kind <= kind;
        i_first_page <= first[9:0];
        i_page_count <= count[10:0];
        forever begin
            @(negedge i_clk);
            if (o_ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        predict_reply(kind, first[9:0], count[10:0]);
    endtask

    task automatic pause_tx(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold the sender until every queued reply has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_gap();
        if (idle_on && $urandom_range(0, 5) == 0) pause_tx($urandom_range(1, 16));
    endtask

    // Receiver: random stall bursts plus long holds asked for by the stimulus.
    always @(posedge i_clk) begin
        if (!running) begin
            i_ready <= 1'b0;
        end else if (holds_asked != holds_done) begin
            holds_done = holds_asked;
            hold_left = 400;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!idle_on) begin
            i_ready <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 15);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Reply checker: a beat seen at the falling edge is taken at the next rising edge.
    always @(negedge i_clk) begin
        t_reply want;
        if (running && o_valid && i_ready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected reply kind=%0d status=%0d start=%0d pages=%0d",
                         $time, o_reply_kind, o_status, o_start_page, o_granted_pages);
                failures++;
            end else begin
                want = replies_due.pop_front();
                if (o_reply_kind !== want.kind) begin
                    $display("%0t: reply_kind expected %0d actual %0d",
                             $time, want.kind, o_reply_kind);
                    failures++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    failures++;
                end
                if (o_start_page !== want.start_page) begin
                    $display("%0t: start_page expected %0d actual %0d",
                             $time, want.start_page, o_start_page);
                    failures++;
                end
                if (o_granted_pages !== want.pages) begin
                    $display("%0t: granted_pages expected %0d actual %0d",
                             $time, want.pages, o_granted_pages);
                    failures++;
                end
            end
        end
    end

    // Edge cases: empty list, range ends, lock states, broken links, ignored kinds.
    task automatic test_directed();
        send_req(K_MALLOC, 0, 0);
        send_req(K_OPEN, 0, 0);
        send_req(K_MALLOC, 0, 1024);
        send_req(K_OPEN, 1000, 1024);
        send_req(K_OPEN, 1023, 1);
        send_req(K_MALLOC, 512, 0);
        send_req(K_MALLOC, 0, 8);
        send_req(K_MALLOC, 0, 1024);
        send_req(K_FREE, 1000, 4);
        send_req(K_RESERVE, 10, 5);
        send_req(K_RESERVE, 990, 20);
        send_req(K_LOCK_SETUP, 10, 0);
        send_req(K_LOCK_SETUP, 10, 2047);
        send_req(K_LOCK_SETUP, 20, 1);
        send_req(K_LOCK_DONE, 11, 0);
        send_req(K_LOCK_SETUP, 11, 0);
        send_req(K_LOCK_DONE, 1005, 0);
        send_req(K_MALLOC, 0, 3);
        send_req(K_RESERVE, 10, 3);
        send_req(3'd6, 341, 682);
        send_req(3'd7, 682, 341);
        send_req(K_OPEN, 0, 1024);
        send_req(K_MALLOC, 0, 16);
        wait_drained();
    endtask

    // One random request, weighted toward well-formed list traffic.
    task automatic random_req();
        int pick, n, first;
        t_run r;
        pick = $urandom_range(0, 99);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 12);
        first = $urandom_range(0, NUM_PAGES - 1);
        if (pick < 30) begin
            send_req(K_MALLOC, first, n);
        end else if (pick < 50) begin
            if (runs_held.size() != 0 && $urandom_range(0, 4) != 0) begin
                r = runs_held[$urandom_range(0, runs_held.size() - 1)];
                send_req(K_FREE, int'(r.first), int'(r.count));
            end else begin
                send_req(K_FREE, first, n);
            end
        end else if (pick < 62) begin
            send_req(K_OPEN, first, n);
        end else if (pick < 74) begin
            send_req(K_RESERVE, first, n);
        end else if (pick < 88) begin
            send_req(K_LOCK_SETUP, first, n);
        end else if (pick < 97) begin
            send_req(K_LOCK_DONE, first, n);
        end else begin
            send_req(3'($urandom_range(6, 7)), first, n);
        end
    endtask

    task automatic test_random(input int items);
        for (int i = 0; i < items; i++) begin
            random_gap();
            random_req();
        end
        wait_drained();
    endtask

    // Long receiver hold while requests keep coming, so the input stalls.
    task automatic test_backpressure();
        holds_asked++;
        for (int i = 0; i < 12; i++) random_req();
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < NUM_PAGES; i++) tag_mirror[i] = TAG_UNSEEN;
        head_mirror = TAG_END;
        running = 1'b1;
        test_directed();
        test_random(120);
        test_backpressure();
        test_random(100);
        idle_on = 1'b0;
        test_random(40);
        i_valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && replies_due.size() == 0) begin
            $display("PASS page_free_list_allocator_unit");
        end else begin
            if (replies_due.size() != 0)
                $display("%0t: %0d replies never arrived", $time, replies_due.size());
            $display("FAIL page_free_list_allocator_unit");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("%0t: timeout", $time);
        $display("FAIL page_free_list_allocator_unit");
        $finish;
    end

endmodule

>>> page_free_list_allocator_unit.f
rtl/core/pfla_pkg.sv
rtl/core/pfla_dp.sv
rtl/core/pfla_ctrl.sv
rtl/core/page_free_list_allocator_unit.sv
tb/tb.sv
